/* design/rgbhsv_pkg.sv */
`timescale 1ns / 1ps

package rgbhsv_pkg;

	localparam int CHAN_W  = 8;
	localparam int NUM_W   = 25;
	localparam int DEN_W   = 16;
	localparam int QUO_W   = 9;
	localparam int PRE_STG = 3;
	localparam int DIV_STG = QUO_W;
	localparam int NUM_STG = PRE_STG + DIV_STG + 1;

	localparam logic [DEN_W-1:0] INV_DEN = DEN_W'(65025);

	typedef enum logic [1:0] {
		MODE_RGB2HSV = 2'd0,
		MODE_RGB2HSL = 2'd1,
		MODE_HSV2RGB = 2'd2,
		MODE_HSL2RGB = 2'd3
	} mode_t;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [DEN_W-1:0]  den_t;
	typedef logic [QUO_W-1:0]  quo_t;

endpackage

/* design/rgb_hsv_hsl_converter_core.sv */
`timescale 1ns / 1ps
// pipeline from input accept to output valid (13 register stages:
// 3 setup stages, 9 restoring divider stages with one quotient bit each, 1 output stage)
// throughput: one item per cycle; each stage holds while its successor stalls
// reset: arst_n clears all stage valid bits and sets mode to rgb to hsv

module rgb_hsv_hsl_converter_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rgbhsv_pkg::chan_t     chan_a,
	input  rgbhsv_pkg::chan_t     chan_b,
	input  rgbhsv_pkg::chan_t     chan_c,
	input  logic                  last_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rgbhsv_pkg::chan_t     out_a,
	output rgbhsv_pkg::chan_t     out_b,
	output rgbhsv_pkg::chan_t     out_c,
	output logic                  last_out
);
	import rgbhsv_pkg::*;

	mode_t mode_q;

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] en;

	// handshake chain
	always_comb begin
		en[NUM_STG-1] = !vld_q[NUM_STG-1] || out_ready;
		for (int k = NUM_STG-2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NUM_STG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			mode_q <= MODE_RGB2HSV;
		end else begin
			if (cfg_we) begin
				mode_q <= mode_t'(cfg_wdata);
			end
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: extremes, hue numerator, sector, chroma products
	chan_t              mx, mn, ch, d_l, cn, ff;
	logic [8:0]         sum;
	logic signed [11:0] qs;
	logic [10:0]        ch6, t6, qw;
	logic [2:0]         sec;
	logic [10:0]        fdiff;
	logic [15:0]        cb, mpb, hb;

	always_comb begin
		mx = (chan_a > chan_b) ? chan_a : chan_b;
		mx = (mx > chan_c) ? mx : chan_c;
		mn = (chan_a < chan_b) ? chan_a : chan_b;
		mn = (mn < chan_c) ? mn : chan_c;
		ch = mx - mn;
		sum = {1'b0, mx} + {1'b0, mn};
		ch6 = 11'(ch) * 11'd6;
		if (mx == chan_a) begin
			qs = $signed({4'b0, chan_b}) - $signed({4'b0, chan_c});
		end else if (mx == chan_b) begin
			qs = $signed({3'b0, ch, 1'b0}) + $signed({4'b0, chan_c})
				- $signed({4'b0, chan_a});
		end else begin
			qs = $signed({2'b0, ch, 2'b0}) + $signed({4'b0, chan_a})
				- $signed({4'b0, chan_b});
		end
		if (qs < 0) begin
			qw = 11'(qs + $signed({1'b0, ch6}));
		end else begin
			qw = qs[10:0];
		end

		t6  = 11'(chan_a) * 11'd6;
		sec = 3'(32'(t6 >= 11'd255) + 32'(t6 >= 11'd510) + 32'(t6 >= 11'd765)
			+ 32'(t6 >= 11'd1020) + 32'(t6 >= 11'd1275) + 32'(t6 >= 11'd1530));
		fdiff = t6 - 11'(11'd255 * 11'(sec));
		if (sec >= 3'd6) begin
			sec = 3'd5;
			ff  = 8'd255;
		end else begin
			ff = fdiff[7:0];
		end

		d_l = (chan_c >= 8'd128) ? 8'({chan_c, 1'b0} - 9'd255)
			: 8'(9'd255 - {chan_c, 1'b0});
		cn = 8'd255 - d_l;
		hb = 16'(cn[7:1]) * 16'(chan_b);
		if (mode_q == MODE_HSV2RGB) begin
			cb  = 16'(chan_b) * 16'(chan_c);
			mpb = 16'(chan_c) * 16'(8'd255 - chan_b);
		end else begin
			cb  = 16'(cn) * 16'(chan_b);
			mpb = 16'(16'(chan_c) * 16'd255 - hb);
		end
	end

	mode_t       mode_s1;
	chan_t       ch_s1, mx_s1, f_s1;
	logic [8:0]  sum_s1;
	logic [10:0] q_s1, ch6_s1;
	logic [2:0]  sec_s1;
	logic [15:0] cb_s1, mpb_s1;
	logic        last_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mode_s1 <= mode_q;
			ch_s1   <= ch;
			mx_s1   <= mx;
			sum_s1  <= sum;
			q_s1    <= qw;
			ch6_s1  <= ch6;
			sec_s1  <= sec;
			f_s1    <= ff;
			cb_s1   <= cb;
			mpb_s1  <= mpb;
			last_s1 <= last_in;
		end
	end

	// stage 2: forward numerators and divisors, inverse products
	num_t        fn [3];
	den_t        fd [3];
	chan_t       hden, third, fx;
	logic [23:0] cp, xp, mp;

	always_comb begin
		hden  = (sum_s1 < 9'd255) ? sum_s1[7:0] : 8'(9'd510 - sum_s1);
		third = (mode_s1 == MODE_RGB2HSV) ? mx_s1 : 8'((10'(sum_s1) + 10'd1) >> 1);
		if (ch_s1 == 8'd0) begin
			fn[0] = '0;
			fd[0] = den_t'(1);
		end else begin
			fn[0] = NUM_W'(q_s1) * NUM_W'(510);
			fd[0] = DEN_W'(ch6_s1);
		end
		if (mode_s1 == MODE_RGB2HSV) begin
			if (mx_s1 == 8'd0) begin
				fn[1] = '0;
				fd[1] = den_t'(1);
			end else begin
				fn[1] = NUM_W'(ch_s1) * NUM_W'(510);
				fd[1] = DEN_W'(mx_s1);
			end
		end else begin
			if (sum_s1 == 9'd0 || sum_s1 == 9'd510) begin
				fn[1] = '0;
				fd[1] = den_t'(1);
			end else begin
				fn[1] = NUM_W'(ch_s1) * NUM_W'(510);
				fd[1] = DEN_W'(hden);
			end
		end
		fn[2] = NUM_W'({third, 1'b0});
		fd[2] = den_t'(1);

		fx = sec_s1[0] ? 8'd255 - f_s1 : f_s1;
		cp = 24'(cb_s1) * 24'd255;
		xp = 24'(cb_s1) * 24'(fx);
		mp = 24'(mpb_s1) * 24'd255;
	end

	mode_t       mode_s2;
	num_t        fn_s2 [3];
	den_t        fd_s2 [3];
	logic [23:0] cp_s2, xp_s2, mp_s2;
	logic [2:0]  sec_s2;
	logic        last_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mode_s2 <= mode_s1;
			fn_s2   <= fn;
			fd_s2   <= fd;
			cp_s2   <= cp;
			xp_s2   <= xp;
			mp_s2   <= mp;
			sec_s2  <= sec_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: sector select and final operands
	logic [23:0] rr, gg, bb;
	num_t        nn [3];
	den_t        dd [3];

	always_comb begin
		unique case (sec_s2)
			3'd0: begin rr = cp_s2; gg = xp_s2; bb = '0;    end
			3'd1: begin rr = xp_s2; gg = cp_s2; bb = '0;    end
			3'd2: begin rr = '0;    gg = cp_s2; bb = xp_s2; end
			3'd3: begin rr = '0;    gg = xp_s2; bb = cp_s2; end
			3'd4: begin rr = xp_s2; gg = '0;    bb = cp_s2; end
			default: begin rr = cp_s2; gg = '0; bb = xp_s2; end
		endcase
		if (mode_s2 == MODE_HSV2RGB || mode_s2 == MODE_HSL2RGB) begin
			nn[0] = NUM_W'({rr + mp_s2, 1'b0});
			nn[1] = NUM_W'({gg + mp_s2, 1'b0});
			nn[2] = NUM_W'({bb + mp_s2, 1'b0});
			dd[0] = INV_DEN;
			dd[1] = INV_DEN;
			dd[2] = INV_DEN;
		end else begin
			nn = fn_s2;
			dd = fd_s2;
		end
	end

	num_t n_s3 [3];
	den_t d_s3 [3];
	logic last_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			n_s3    <= nn;
			d_s3    <= dd;
			last_s3 <= last_s2;
		end
	end

	// restoring divider, one quotient bit per stage, msb first
	num_t dv_rem_sd [DIV_STG][3];
	den_t dv_den_sd [DIV_STG][3];
	quo_t dv_quo_sd [DIV_STG][3];
	logic dv_last_sd [DIV_STG];

	num_t nx_rem [DIV_STG][3];
	quo_t nx_quo [DIV_STG][3];

	always_comb begin
		for (int k = 0; k < DIV_STG; k++) begin
			for (int j = 0; j < 3; j++) begin
				num_t src_rem, sh;
				den_t src_den;
				quo_t src_quo;
				src_rem = (k == 0) ? n_s3[j] : dv_rem_sd[(k == 0) ? 0 : k-1][j];
				src_den = (k == 0) ? d_s3[j] : dv_den_sd[(k == 0) ? 0 : k-1][j];
				src_quo = (k == 0) ? '0 : dv_quo_sd[(k == 0) ? 0 : k-1][j];
				sh = NUM_W'(src_den) << (QUO_W - 1 - k);
				if (src_rem >= sh) begin
					nx_rem[k][j] = src_rem - sh;
					nx_quo[k][j] = {src_quo[QUO_W-2:0], 1'b1};
				end else begin
					nx_rem[k][j] = src_rem;
					nx_quo[k][j] = {src_quo[QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STG; k++) begin
			if (en[PRE_STG+k]) begin
				for (int j = 0; j < 3; j++) begin
					dv_rem_sd[k][j] <= nx_rem[k][j];
					dv_quo_sd[k][j] <= nx_quo[k][j];
					dv_den_sd[k][j] <= (k == 0) ? d_s3[j] : dv_den_sd[(k == 0) ? 0 : k-1][j];
				end
				dv_last_sd[k] <= (k == 0) ? last_s3 : dv_last_sd[(k == 0) ? 0 : k-1];
			end
		end
	end

	// round half up from the doubled quotient, clamp to 255
	chan_t res [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic [QUO_W:0] qp;
			qp = {1'b0, dv_quo_sd[DIV_STG-1][j]} + (QUO_W+1)'(1);
			res[j] = qp[QUO_W] ? 8'd255 : qp[QUO_W-1:1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NUM_STG-1]) begin
			out_a    <= res[0];
			out_b    <= res[1];
			out_c    <= res[2];
			last_out <= dv_last_sd[DIV_STG-1];
		end
	end

`ifndef SYNTHESIS
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[PRE_STG-1] |-> d_s3[0] != '0 && d_s3[1] != '0 && d_s3[2] != '0)
		else $error("zero divisor entered divider");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NUM_STG-2] |->
		dv_rem_sd[DIV_STG-1][0] < NUM_W'(dv_den_sd[DIV_STG-1][0]) &&
		dv_rem_sd[DIV_STG-1][1] < NUM_W'(dv_den_sd[DIV_STG-1][1]) &&
		dv_rem_sd[DIV_STG-1][2] < NUM_W'(dv_den_sd[DIV_STG-1][2]))
		else $error("divider quotient overflow");
`endif

endmodule
